[rtl/core/scpu_pkg.sv]
// ============================================================================
// scpu_pkg
// Shared types and Q30 angle constants for the sine/cosine polynomial unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package scpu_pkg;

    // Working format: unsigned Q30
    localparam int W_BITS = 30;
    // Reduced angle in Q30, always below 2^33
    localparam int X_BITS = 33;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // pi scaled by a power of two, taken from the Q60 value with a
    // round-half-up right shift of sh bits
    function automatic logic [63:0] f_pi_const(input int sh);
        return (PI_Q60 + (64'd1 << (sh - 1))) >> sh;
    endfunction

    localparam logic [63:0] PI_W64      = f_pi_const(60 - W_BITS);
    localparam logic [63:0] HALF_W64    = f_pi_const(60 - W_BITS + 1);
    localparam logic [63:0] QUARTER_W64 = f_pi_const(60 - W_BITS + 2);
    localparam logic [63:0] TAU_W64     = f_pi_const(60 - W_BITS - 1);

    localparam logic [X_BITS-1:0] PI_W      = PI_W64[X_BITS-1:0];
    localparam logic [X_BITS-1:0] HALF_W    = HALF_W64[X_BITS-1:0];
    localparam logic [X_BITS-1:0] QUARTER_W = QUARTER_W64[X_BITS-1:0];
    localparam logic [X_BITS-1:0] TAU_W     = TAU_W64[X_BITS-1:0];
    // Third quadrant edge: sum of the rounded constants
    localparam logic [X_BITS-1:0] PI_HALF_W = PI_W + HALF_W;

    // Per-request control after quadrant and octant folding
    typedef struct packed {
        logic neg;
        logic use_cos;
    } t_ctl;

endpackage

`default_nettype wire

[rtl/core/scpu_reduce.sv]
// ============================================================================
// scpu_reduce
// Angle reduction modulo 2*pi: reciprocal multiply, back multiply, subtract,
// one-step correction; result scaled into Q30.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module scpu_reduce import scpu_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [31:0]       i_angle,
    input  logic                     i_opcode,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [X_BITS-1:0]        o_x,
    output logic                     o_opcode
);

    localparam logic [63:0] TAU_A64  = f_pi_const(60 - ANGLE_FRAC_BITS - 1);
    localparam int          TB       = $clog2(TAU_A64 + 64'd1);
    localparam logic [TB-1:0] TAU_A  = TAU_A64[TB-1:0];
    // floor(2^32 / tau): quotient estimate is off by at most one
    localparam logic [63:0] RECIP64  = (64'd1 << 32) / TAU_A64;
    localparam int          RB       = $clog2(RECIP64 + 64'd1);
    localparam logic [RB-1:0] RECIP  = RECIP64[RB-1:0];
    localparam int          QB       = 34 - TB;
    localparam int          PW       = 33 + RB;
    localparam int          DB       = QB + TB + 1;
    localparam int          RW       = TB + 2;
    localparam int          SH       = W_BITS - ANGLE_FRAC_BITS;

    logic                   r1_vld, r2_vld, r3_vld, r4_vld;
    logic                   w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic signed [QB-1:0]   r1_q;
    logic signed [31:0]     r1_a;
    logic                   r1_op;
    logic signed [DB-1:0]   r2_prod;
    logic signed [31:0]     r2_a;
    logic                   r2_op;
    logic signed [RW-1:0]   r3_r;
    logic                   r3_op;
    logic [X_BITS-1:0]      r4_x;
    logic                   r4_op;

    logic signed [PW-1:0]   w_prod1;
    logic signed [DB-1:0]   w_prod2;
    logic signed [DB-1:0]   w_diff;
    logic signed [RW-1:0]   w_add;
    logic signed [RW-1:0]   w_sub;
    logic signed [RW-1:0]   w_fix;
    logic [X_BITS-1:0]      n4_x;

    assign w_rdy4  = !r4_vld || i_ready;
    assign w_rdy3  = !r3_vld || w_rdy4;
    assign w_rdy2  = !r2_vld || w_rdy3;
    assign w_rdy1  = !r1_vld || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_prod1 = i_angle * $signed({1'b0, RECIP});
    assign w_prod2 = r1_q * $signed({1'b0, TAU_A});
    assign w_diff  = r2_a - r2_prod;

    // remainder estimate lies in [-tau, 2*tau)
    assign w_add = r3_r + $signed({2'b00, TAU_A});
    assign w_sub = r3_r - $signed({2'b00, TAU_A});

    always_comb begin
        priority if (r3_r[RW-1]) begin
            w_fix = w_add;
        end else if (r3_r >= $signed({2'b00, TAU_A})) begin
            w_fix = w_sub;
        end else begin
            w_fix = r3_r;
        end
        n4_x = X_BITS'(w_fix[TB-1:0]) << SH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (w_rdy1) r1_vld <= i_valid;
            if (w_rdy2) r2_vld <= r1_vld;
            if (w_rdy3) r3_vld <= r2_vld;
            if (w_rdy4) r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_q  <= w_prod1[32 +: QB];
            r1_a  <= i_angle;
            r1_op <= i_opcode;
        end
        if (w_rdy2 && r1_vld) begin
            r2_prod <= w_prod2;
            r2_a    <= r1_a;
            r2_op   <= r1_op;
        end
        if (w_rdy3 && r2_vld) begin
            r3_r  <= w_diff[RW-1:0];
            r3_op <= r2_op;
        end
        if (w_rdy4 && r3_vld) begin
            r4_x  <= n4_x;
            r4_op <= r3_op;
        end
    end

    assign o_valid  = r4_vld;
    assign o_x      = r4_x;
    assign o_opcode = r4_op;

endmodule

`default_nettype wire

[rtl/core/scpu_fold.sv]
// ============================================================================
// scpu_fold
// Quadrant fold with sign, then octant switch to the other function above
// pi/4. Two register stages.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module scpu_fold import scpu_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [X_BITS-1:0]   i_x,
    input  logic                i_opcode,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [W_BITS-1:0]   o_x,
    output t_ctl                o_ctl
);

    logic                   r5_vld, r6_vld;
    logic                   w_rdy5, w_rdy6;

    logic [W_BITS:0]        r5_x;
    logic                   r5_neg;
    logic                   r5_op;
    logic [W_BITS-1:0]      r6_x;
    t_ctl                   r6_ctl;

    logic signed [X_BITS:0] w_d;
    logic [W_BITS:0]        n5_x;
    logic                   n5_neg;
    logic signed [X_BITS:0] w_oct;
    logic [W_BITS-1:0]      n6_x;
    t_ctl                   n6_ctl;

    assign w_rdy6  = !r6_vld || i_ready;
    assign w_rdy5  = !r5_vld || w_rdy6;
    assign o_ready = w_rdy5;

    always_comb begin
        priority if (i_x < HALF_W) begin
            w_d    = $signed({1'b0, i_x});
            n5_neg = 1'b0;
        end else if (i_x < PI_W) begin
            w_d    = $signed({1'b0, PI_W}) - $signed({1'b0, i_x});
            n5_neg = i_opcode;
        end else if (i_x < PI_HALF_W) begin
            w_d    = $signed({1'b0, i_x}) - $signed({1'b0, PI_W});
            n5_neg = 1'b1;
        end else begin
            // constant rounding can push this slightly below zero
            w_d    = $signed({1'b0, TAU_W}) - $signed({1'b0, i_x});
            n5_neg = !i_opcode;
        end
        n5_x = w_d[X_BITS] ? '0 : w_d[W_BITS:0];
    end

    always_comb begin
        w_oct          = $signed({1'b0, HALF_W}) - $signed((X_BITS + 1)'(r5_x));
        n6_ctl.neg     = r5_neg;
        if ((X_BITS)'(r5_x) > QUARTER_W) begin
            n6_ctl.use_cos = !r5_op;
            n6_x           = w_oct[X_BITS] ? '0 : w_oct[W_BITS-1:0];
        end else begin
            n6_ctl.use_cos = r5_op;
            n6_x           = r5_x[W_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            if (w_rdy5) r5_vld <= i_valid;
            if (w_rdy6) r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && i_valid) begin
            r5_x   <= n5_x;
            r5_neg <= n5_neg;
            r5_op  <= i_opcode;
        end
        if (w_rdy6 && r5_vld) begin
            r6_x   <= n6_x;
            r6_ctl <= n6_ctl;
        end
    end

    assign o_valid = r6_vld;
    assign o_x     = r6_x;
    assign o_ctl   = r6_ctl;

endmodule

`default_nettype wire

[rtl/core/scpu_poly.sv]
// ============================================================================
// scpu_poly
// Shared power chain and series sum for sine (x, x^3, x^5) and cosine
// (x^2, x^4, x^6) in Q30. Five register stages.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module scpu_poly import scpu_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [W_BITS-1:0]   i_x,
    input  t_ctl                i_ctl,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [W_BITS:0]     o_m,
    output logic                o_neg
);

    // Exact floor division of values below 2^30: (v * ceil(2^(30+l)/d)) >> (30+l)
    localparam int SH_DIV6   = W_BITS + 3;
    localparam int SH_DIV24  = W_BITS + 5;
    localparam int SH_DIV120 = W_BITS + 7;
    localparam int SH_DIV720 = W_BITS + 10;
    localparam logic [63:0] MAGIC_DIV6_64   = ((64'd1 << SH_DIV6) + 64'd5) / 64'd6;
    localparam logic [63:0] MAGIC_DIV120_64 = ((64'd1 << SH_DIV120) + 64'd119) / 64'd120;
    localparam logic [63:0] MAGIC_DIV720_64 = ((64'd1 << SH_DIV720) + 64'd719) / 64'd720;
    // 2^35/24 rounds up to the same multiplier as 2^33/6
    localparam logic [W_BITS:0] MAGIC_Y   = MAGIC_DIV6_64[W_BITS:0];
    localparam logic [W_BITS:0] MAGIC_120 = MAGIC_DIV120_64[W_BITS:0];
    localparam logic [W_BITS:0] MAGIC_720 = MAGIC_DIV720_64[W_BITS:0];
    localparam logic signed [W_BITS+1:0] ONE_W = (W_BITS + 2)'(1) << W_BITS;

    // Q30 product, rounded half up
    function automatic logic [W_BITS-1:0] f_qmul(input logic [W_BITS-1:0] a,
                                                 input logic [W_BITS-1:0] b);
        logic [2*W_BITS:0] p;
        p = (2*W_BITS + 1)'(a) * (2*W_BITS + 1)'(b);
        p = p + ((2*W_BITS + 1)'(1) << (W_BITS - 1));
        return p[W_BITS +: W_BITS];
    endfunction

    logic                   r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic                   w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    logic [W_BITS-1:0]      r1_x, r1_x2;
    t_ctl                   r1_ctl;
    logic [W_BITS-1:0]      r2_x, r2_x2, r2_y;
    t_ctl                   r2_ctl;
    logic [W_BITS-1:0]      r3_x, r3_x2, r3_y, r3_z;
    t_ctl                   r3_ctl;
    logic [W_BITS-1:0]      r4_lin, r4_yq, r4_zq;
    t_ctl                   r4_ctl;
    logic [W_BITS:0]        r5_m;
    logic                   r5_neg;

    logic [2*W_BITS:0]      w_py, w_pz;
    logic [W_BITS-1:0]      n4_yq, n4_zq;
    logic signed [W_BITS+1:0] w_sum;

    assign w_rdy5  = !r5_vld || i_ready;
    assign w_rdy4  = !r4_vld || w_rdy5;
    assign w_rdy3  = !r3_vld || w_rdy4;
    assign w_rdy2  = !r2_vld || w_rdy3;
    assign w_rdy1  = !r1_vld || w_rdy2;
    assign o_ready = w_rdy1;

    // y is x^3 (sine) or x^4 (cosine); z is x^5 or x^6
    always_comb begin
        w_py = (2*W_BITS + 1)'(r3_y) * (2*W_BITS + 1)'(MAGIC_Y);
        if (r3_ctl.use_cos) begin
            w_pz  = (2*W_BITS + 1)'(r3_z) * (2*W_BITS + 1)'(MAGIC_720);
            n4_yq = W_BITS'(w_py >> SH_DIV24);
            n4_zq = W_BITS'(w_pz >> SH_DIV720);
        end else begin
            w_pz  = (2*W_BITS + 1)'(r3_z) * (2*W_BITS + 1)'(MAGIC_120);
            n4_yq = W_BITS'(w_py >> SH_DIV6);
            n4_zq = W_BITS'(w_pz >> SH_DIV120);
        end
    end

    always_comb begin
        if (r4_ctl.use_cos) begin
            w_sum = ONE_W - $signed((W_BITS + 2)'(r4_lin))
                  + $signed((W_BITS + 2)'(r4_yq)) - $signed((W_BITS + 2)'(r4_zq));
        end else begin
            w_sum = $signed((W_BITS + 2)'(r4_lin))
                  - $signed((W_BITS + 2)'(r4_yq)) + $signed((W_BITS + 2)'(r4_zq));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            if (w_rdy1) r1_vld <= i_valid;
            if (w_rdy2) r2_vld <= r1_vld;
            if (w_rdy3) r3_vld <= r2_vld;
            if (w_rdy4) r4_vld <= r3_vld;
            if (w_rdy5) r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_x   <= i_x;
            r1_x2  <= f_qmul(i_x, i_x);
            r1_ctl <= i_ctl;
        end
        if (w_rdy2 && r1_vld) begin
            r2_x   <= r1_x;
            r2_x2  <= r1_x2;
            r2_y   <= f_qmul(r1_x2, r1_ctl.use_cos ? r1_x2 : r1_x);
            r2_ctl <= r1_ctl;
        end
        if (w_rdy3 && r2_vld) begin
            r3_x   <= r2_x;
            r3_x2  <= r2_x2;
            r3_y   <= r2_y;
            r3_z   <= f_qmul(r2_y, r2_x2);
            r3_ctl <= r2_ctl;
        end
        if (w_rdy4 && r3_vld) begin
            r4_lin <= r3_ctl.use_cos ? (r3_x2 >> 1) : r3_x;
            r4_yq  <= n4_yq;
            r4_zq  <= n4_zq;
            r4_ctl <= r3_ctl;
        end
        if (w_rdy5 && r4_vld) begin
            r5_m   <= w_sum[W_BITS+1] ? '0 : w_sum[W_BITS:0];
            r5_neg <= r4_ctl.neg;
        end
    end

    assign o_valid = r5_vld;
    assign o_m     = r5_m;
    assign o_neg   = r5_neg;

endmodule

`default_nettype wire

[rtl/core/sine_cosine_polynomial_unit.sv]
// ============================================================================
// sine_cosine_polynomial_unit
// Sine or cosine of a fixed-point angle in radians by range reduction,
// quadrant/octant folding and short Taylor series; saturated signed result.
// ============================================================================
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  request  | i_valid / o_ready   | i_angle (signed, Q.ANGLE_FRAC_BITS),
//           |                     | i_opcode (0 sine, 1 cosine)
//  result   | o_valid / i_ready   | o_value (signed, Q1.RESULT_FRAC_BITS)
//
//  Registered stages in order: reduction modulo 2*pi, folding, the power
//  chain and series sum, then rounding and saturation.
//  One request is taken every cycle while results are drained.
//  Each stage holds its own valid bit; a stalled result only backs up the
//  stages behind it, and empty stages keep filling.
//  Synchronous active-low reset clears all valid bits; no other state.
//
`timescale 1ns / 1ps
`default_nettype none

module sine_cosine_polynomial_unit import scpu_pkg::*; #(
    parameter int ANGLE_FRAC_BITS  = 16,
    parameter int RESULT_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [31:0]                i_angle,
    input  logic                              i_opcode,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [RESULT_FRAC_BITS+1:0] o_value
);

    localparam int VB = RESULT_FRAC_BITS + 2;
    localparam int SH = W_BITS - RESULT_FRAC_BITS;
    localparam logic [W_BITS+1:0]     ONE_R     = (W_BITS + 2)'(1) << RESULT_FRAC_BITS;
    localparam logic signed [VB-1:0]  ONE_V     = VB'(1) << RESULT_FRAC_BITS;
    localparam logic signed [VB-1:0]  NEG_ONE_V = -ONE_V;

    logic                   w_red_vld, w_red_rdy;
    logic [X_BITS-1:0]      w_red_x;
    logic                   w_red_op;
    logic                   w_fold_vld, w_fold_rdy;
    logic [W_BITS-1:0]      w_fold_x;
    t_ctl                   w_fold_ctl;
    logic                   w_poly_vld, w_poly_rdy;
    logic [W_BITS:0]        w_poly_m;
    logic                   w_poly_neg;

    logic                   r_vld;
    logic signed [VB-1:0]   r_value;
    logic [W_BITS+1:0]      w_rnd;
    logic [RESULT_FRAC_BITS:0] w_mag;
    logic signed [VB-1:0]   n_value;

    scpu_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_angle  (i_angle),
        .i_opcode (i_opcode),
        .o_valid  (w_red_vld),
        .i_ready  (w_red_rdy),
        .o_x      (w_red_x),
        .o_opcode (w_red_op)
    );

    scpu_fold u_fold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_red_vld),
        .o_ready  (w_red_rdy),
        .i_x      (w_red_x),
        .i_opcode (w_red_op),
        .o_valid  (w_fold_vld),
        .i_ready  (w_fold_rdy),
        .o_x      (w_fold_x),
        .o_ctl    (w_fold_ctl)
    );

    scpu_poly u_poly (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_fold_vld),
        .o_ready  (w_fold_rdy),
        .i_x      (w_fold_x),
        .i_ctl    (w_fold_ctl),
        .o_valid  (w_poly_vld),
        .i_ready  (w_poly_rdy),
        .o_m      (w_poly_m),
        .o_neg    (w_poly_neg)
    );

    // round half up on the magnitude, clip at one, then apply the sign
    always_comb begin
        w_rnd = ((W_BITS + 2)'(w_poly_m) + ((W_BITS + 2)'(1) << (SH - 1))) >> SH;
        if (w_rnd > ONE_R) begin
            w_mag = ONE_R[RESULT_FRAC_BITS:0];
        end else begin
            w_mag = w_rnd[RESULT_FRAC_BITS:0];
        end
        n_value = w_poly_neg ? -$signed(VB'(w_mag)) : $signed(VB'(w_mag));
    end

    assign w_poly_rdy = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_poly_rdy) begin
            r_vld <= w_poly_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_poly_rdy && w_poly_vld) begin
            r_value <= n_value;
        end
    end

    assign o_valid = r_vld;
    assign o_value = r_value;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value <= ONE_V) && (o_value >= NEG_ONE_V))
        else $error("result outside plus or minus one");

    a_octant_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fold_vld |-> ((X_BITS)'(w_fold_x) <= QUARTER_W))
        else $error("folded angle above pi/4");

    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("request refused with empty output stage");

    a_poly_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_poly_vld && o_valid && !i_ready) |=> $stable(w_poly_m))
        else $error("series result changed while held");

endmodule

`default_nettype wire
